@@ rtl/core/bnis_pkg.sv @@
// Shared types and codes for the B+ tree internal node insert/split unit.
// Request and result structs, command and status codes, controller states.
// No dependencies.
package bnis_pkg;

    localparam int KeyWidth   = 32;
    localparam int ChildWidth = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SPLIT  = 2'd1,
        CMD_INIT   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_REJECT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_SPL_RD,
        ST_SPL_CAP,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [1:0]                   cmd;
        logic signed [KeyWidth-1:0]   key;
        logic [ChildWidth-1:0]        child;
    } in_t;

    typedef struct packed {
        logic [1:0]                   status;
        logic signed [KeyWidth-1:0]   key_res;
        logic [ChildWidth-1:0]        child_res;
        logic                         last;
    } out_t;

endpackage

@@ rtl/core/bnis_mem.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the key and child stores. No package dependency.
module bnis_mem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/btree_node_insert_split_unit.sv @@
// Top level of the B+ tree internal node insert/split unit.
// Depends on bnis_pkg and bnis_mem (key store and child store).
//
// Usage: requests arrive on s_valid/s_ready/s_data, results leave on
// m_valid/m_ready/m_data, every result carries last on its final item.
// init writes the leftmost child and empties the node. insert searches from
// the top key down, moving one key and one child up per cycle until its
// slot is found; the pace is set by the single read and write port of each
// store. split streams the upper n - n/2 entries, each one read from the
// stores once the result register is free, then loaded into it.
// One request is worked on at a time; s_ready is high whenever the
// controller is idle, also while an earlier result waits in the output
// register. A stalled receiver holds the result register; a pending
// result or split item waits for it to drain. Reset clears the key count,
// the controller and the output valid; store contents are undefined until
// written, so a node must be initialized before use.
module btree_node_insert_split_unit #(
    parameter int CAPACITY = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bnis_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bnis_pkg::out_t   m_data
);

    localparam int AW_K = $clog2(CAPACITY);
    localparam int AW_C = $clog2(CAPACITY + 1);
    localparam int NW   = $clog2(CAPACITY + 1);

    bnis_pkg::state_t state_reg, state_next;
    bnis_pkg::in_t    req_reg, req_next;
    logic [NW-1:0]    count_reg, count_next;
    logic [AW_K-1:0]  idx_reg, idx_next;
    logic [NW-1:0]    ptr_reg, ptr_next;
    logic [NW-1:0]    end_reg, end_next;
    logic [1:0]       resp_reg, resp_next;
    logic             out_valid_reg;
    bnis_pkg::out_t   out_reg;

    logic                              key_we, key_re;
    logic [AW_K-1:0]                   key_waddr, key_raddr;
    logic [bnis_pkg::KeyWidth-1:0]     key_wdata, key_rdata;
    logic                              child_we, child_re;
    logic [AW_C-1:0]                   child_waddr, child_raddr;
    logic [bnis_pkg::ChildWidth-1:0]   child_wdata, child_rdata;

    logic           accept;
    logic           out_free;
    logic           key_less;
    logic           spl_last;
    logic           out_load;
    bnis_pkg::out_t out_load_data;

    bnis_mem #(
        .WIDTH (bnis_pkg::KeyWidth),
        .DEPTH (CAPACITY)
    ) u_key_mem (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    bnis_mem #(
        .WIDTH (bnis_pkg::ChildWidth),
        .DEPTH (CAPACITY + 1)
    ) u_child_mem (
        .aclk  (aclk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .re    (child_re),
        .raddr (child_raddr),
        .rdata (child_rdata)
    );

    assign s_ready  = (state_reg == bnis_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign key_less = $signed(req_reg.key) < $signed(key_rdata);
    assign spl_last = (ptr_reg + NW'(1)) == end_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bnis_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.cmd)
                        bnis_pkg::CMD_INSERT: begin
                            if (count_reg >= NW'(CAPACITY)) begin
                                state_next = bnis_pkg::ST_RESP;
                            end else if (count_reg == '0) begin
                                state_next = bnis_pkg::ST_INS_PUT;
                            end else begin
                                state_next = bnis_pkg::ST_INS_CMP;
                            end
                        end
                        bnis_pkg::CMD_SPLIT: begin
                            if (count_reg == '0) begin
                                state_next = bnis_pkg::ST_RESP;
                            end else begin
                                state_next = bnis_pkg::ST_SPL_RD;
                            end
                        end
                        default: state_next = bnis_pkg::ST_RESP;
                    endcase
                end
            end
            bnis_pkg::ST_INS_CMP: begin
                if (!key_less) begin
                    state_next = bnis_pkg::ST_RESP;
                end else if (idx_reg == '0) begin
                    state_next = bnis_pkg::ST_INS_PUT;
                end
            end
            bnis_pkg::ST_INS_PUT: state_next = bnis_pkg::ST_RESP;
            bnis_pkg::ST_SPL_RD: begin
                if (out_free) begin
                    state_next = bnis_pkg::ST_SPL_CAP;
                end
            end
            bnis_pkg::ST_SPL_CAP: begin
                state_next = spl_last ? bnis_pkg::ST_IDLE : bnis_pkg::ST_SPL_RD;
            end
            bnis_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = bnis_pkg::ST_IDLE;
                end
            end
            default: state_next = bnis_pkg::ST_IDLE;
        endcase
    end

    // store accesses and datapath
    always_comb begin
        key_we        = 1'b0;
        key_waddr     = '0;
        key_wdata     = '0;
        key_re        = 1'b0;
        key_raddr     = '0;
        child_we      = 1'b0;
        child_waddr   = '0;
        child_wdata   = '0;
        child_re      = 1'b0;
        child_raddr   = '0;
        req_next      = req_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        ptr_next      = ptr_reg;
        end_next      = end_reg;
        resp_next     = resp_reg;
        out_load      = 1'b0;
        out_load_data = '0;
        unique case (state_reg)
            bnis_pkg::ST_IDLE: begin
                if (accept) begin
                    req_next  = s_data;
                    resp_next = bnis_pkg::STATUS_REJECT;
                    case (s_data.cmd)
                        bnis_pkg::CMD_INSERT: begin
                            if (count_reg < NW'(CAPACITY) && count_reg != '0) begin
                                // start at the top key, child right of it
                                key_re      = 1'b1;
                                key_raddr   = AW_K'(count_reg - NW'(1));
                                child_re    = 1'b1;
                                child_raddr = AW_C'(count_reg);
                                idx_next    = AW_K'(count_reg - NW'(1));
                            end
                        end
                        bnis_pkg::CMD_SPLIT: begin
                            if (count_reg != '0) begin
                                ptr_next   = count_reg >> 1;
                                end_next   = count_reg;
                                count_next = count_reg >> 1;
                            end
                        end
                        bnis_pkg::CMD_INIT: begin
                            child_we    = 1'b1;
                            child_waddr = '0;
                            child_wdata = s_data.child;
                            count_next  = '0;
                            resp_next   = bnis_pkg::STATUS_OK;
                        end
                        default: ;
                    endcase
                end
            end
            bnis_pkg::ST_INS_CMP: begin
                key_we      = 1'b1;
                key_waddr   = idx_reg + AW_K'(1);
                child_we    = 1'b1;
                child_waddr = AW_C'(idx_reg) + AW_C'(2);
                if (key_less) begin
                    // move entry up one slot, then look one lower
                    key_wdata   = key_rdata;
                    child_wdata = child_rdata;
                    if (idx_reg != '0) begin
                        key_re      = 1'b1;
                        key_raddr   = idx_reg - AW_K'(1);
                        child_re    = 1'b1;
                        child_raddr = AW_C'(idx_reg);
                        idx_next    = idx_reg - AW_K'(1);
                    end
                end else begin
                    key_wdata   = req_reg.key;
                    child_wdata = req_reg.child;
                    count_next  = count_reg + NW'(1);
                    resp_next   = (count_reg == NW'(CAPACITY - 1)) ?
                                  bnis_pkg::STATUS_FULL : bnis_pkg::STATUS_OK;
                end
            end
            bnis_pkg::ST_INS_PUT: begin
                key_we      = 1'b1;
                key_waddr   = '0;
                key_wdata   = req_reg.key;
                child_we    = 1'b1;
                child_waddr = AW_C'(1);
                child_wdata = req_reg.child;
                count_next  = count_reg + NW'(1);
                resp_next   = (count_reg == NW'(CAPACITY - 1)) ?
                              bnis_pkg::STATUS_FULL : bnis_pkg::STATUS_OK;
            end
            bnis_pkg::ST_SPL_RD: begin
                if (out_free) begin
                    key_re      = 1'b1;
                    key_raddr   = AW_K'(ptr_reg);
                    child_re    = 1'b1;
                    child_raddr = AW_C'(ptr_reg + NW'(1));
                end
            end
            bnis_pkg::ST_SPL_CAP: begin
                out_load                = 1'b1;
                out_load_data.status    = bnis_pkg::STATUS_OK;
                out_load_data.key_res   = key_rdata;
                out_load_data.child_res = child_rdata;
                out_load_data.last      = spl_last;
                ptr_next                = ptr_reg + NW'(1);
            end
            bnis_pkg::ST_RESP: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_load_data.status = resp_reg;
                    out_load_data.last   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bnis_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        idx_reg  <= idx_next;
        ptr_reg  <= ptr_next;
        end_reg  <= end_next;
        resp_reg <= resp_next;
        if (out_load) begin
            out_reg <= out_load_data;
        end
    end

    // a result is only loaded when the output register is free or drains
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NW'(CAPACITY))
        else $error("key count above capacity");

    // no same-cycle read and write of one entry during the shift
    a_key_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (key_we && key_re) |-> (key_waddr != key_raddr))
        else $error("key store read/write clash");

    a_child_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (child_we && child_re) |-> (child_waddr != child_raddr))
        else $error("child store read/write clash");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != bnis_pkg::ST_IDLE))
        else $error("request accepted without work");

endmodule

@@ dv/tb_btree_node_insert_split_unit.sv @@
// Self-checking testbench for btree_node_insert_split_unit: a directed table,
// then random insert, split, init and unknown-command runs, checked against a
// behavioral node model or the table's status. Depends on bnis_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_btree_node_insert_split_unit;

    localparam int NODE_CAP     = 32;
    localparam int RANDOM_REQS  = 150;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 300000;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        bnis_pkg::in_t     req;
        logic              known;
        bnis_pkg::status_t status;
    } dir_row_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    bnis_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    bnis_pkg::out_t m_data;

    btree_node_insert_split_unit #(
        .CAPACITY(NODE_CAP)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // node model
    logic signed [bnis_pkg::KeyWidth-1:0] node_keys [NODE_CAP];
    logic [bnis_pkg::ChildWidth-1:0]      node_children [NODE_CAP+1];
    int                                   node_count = 0;
    bnis_pkg::out_t                       node_results_q [$];

    dir_row_t          dir_rows [$];
    int                total_reqs   = 1;
    int                req_offered  = 0;
    int                req_accepted = 0;
    int                idle_phase   = 0;
    logic              cur_known    = 1'b0;
    bnis_pkg::status_t cur_status   = bnis_pkg::STATUS_OK;
    int                gen_count    = 0;
    int                ins_left     = NODE_CAP + 2;  // first random run fills the node
    int                mismatches   = 0;
    int                cycle_count  = 0;
    int                hold_cycles  = 0;
    logic              hold_done    = 1'b0;
    bnis_pkg::out_t    want_res;

    function automatic void push_node_result(bnis_pkg::status_t st,
                                             logic signed [bnis_pkg::KeyWidth-1:0] k,
                                             logic [bnis_pkg::ChildWidth-1:0] c,
                                             logic lst);
        bnis_pkg::out_t r;
        r.status    = st;
        r.key_res   = k;
        r.child_res = c;
        r.last      = lst;
        node_results_q.push_back(r);
    endfunction

    // Updates the node and, when record is set, queues the results it produces.
    function automatic void node_apply(bnis_pkg::in_t req, logic record);
        logic signed [bnis_pkg::KeyWidth-1:0] new_key;
        int n, slot, mid, i;
        new_key = req.key;
        n = node_count;
        case (req.cmd)
            bnis_pkg::CMD_INSERT: begin
                if (n >= NODE_CAP) begin
                    if (record) push_node_result(bnis_pkg::STATUS_REJECT, '0, '0, 1'b1);
                end else begin
                    slot = 0;
                    // equal keys: new key lands after existing ones
                    while (slot < n && !(new_key < node_keys[slot])) slot++;
                    for (i = n; i > slot; i--) begin
                        node_keys[i]       = node_keys[i-1];
                        node_children[i+1] = node_children[i];
                    end
                    node_keys[slot]       = new_key;
                    node_children[slot+1] = req.child;
                    node_count            = n + 1;
                    if (record) begin
                        if (node_count >= NODE_CAP)
                            push_node_result(bnis_pkg::STATUS_FULL, '0, '0, 1'b1);
                        else
                            push_node_result(bnis_pkg::STATUS_OK, '0, '0, 1'b1);
                    end
                end
            end
            bnis_pkg::CMD_SPLIT: begin
                if (n == 0) begin
                    if (record) push_node_result(bnis_pkg::STATUS_REJECT, '0, '0, 1'b1);
                end else begin
                    mid = n / 2;
                    for (i = 0; i < n - mid; i++) begin
                        if (record)
                            push_node_result(bnis_pkg::STATUS_OK, node_keys[mid+i],
                                             node_children[mid+1+i], i == n - mid - 1);
                    end
                    node_count = mid;
                end
            end
            bnis_pkg::CMD_INIT: begin
                node_count       = 0;
                node_children[0] = req.child;
                if (record) push_node_result(bnis_pkg::STATUS_OK, '0, '0, 1'b1);
            end
            default: begin
                if (record) push_node_result(bnis_pkg::STATUS_REJECT, '0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic void add_row(logic [1:0] cmd, logic [31:0] key, logic [31:0] child,
                                    logic known, bnis_pkg::status_t st);
        dir_row_t row;
        row.req.cmd   = cmd;
        row.req.key   = key;
        row.req.child = child;
        row.known     = known;
        row.status    = st;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [31:0] rand_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) return 32'($signed($urandom_range(0, 8)) - 4);  // many equal keys
        if (pick < 40) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7fff_ffff;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_child();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 32'h0000_0000;
        if (pick == 1) return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Next request: directed table first, then random runs of inserts
    // separated by split, init or an unknown command.
    function automatic bnis_pkg::in_t next_request();
        bnis_pkg::in_t req;
        int            pick;
        logic          was_insert;
        if (req_offered < dir_rows.size()) begin
            req        = dir_rows[req_offered].req;
            cur_known  = dir_rows[req_offered].known;
            cur_status = dir_rows[req_offered].status;
        end else begin
            cur_known = 1'b0;
            req.key   = rand_key();
            req.child = rand_child();
            if (ins_left > 0) begin
                ins_left--;
                req.cmd = bnis_pkg::CMD_INSERT;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 8) req.cmd = CMD_UNKNOWN;
                else if (pick < 25) req.cmd = bnis_pkg::CMD_INIT;
                else req.cmd = bnis_pkg::CMD_SPLIT;
            end
        end
        was_insert = (req.cmd == bnis_pkg::CMD_INSERT);
        case (req.cmd)
            bnis_pkg::CMD_INSERT: if (gen_count < NODE_CAP) gen_count++;
            bnis_pkg::CMD_SPLIT:  gen_count = gen_count / 2;
            bnis_pkg::CMD_INIT:   gen_count = 0;
            default:              ;
        endcase
        if (req_offered >= dir_rows.size() && !was_insert) begin
            // a third of the runs overfill the node
            if ($urandom_range(0, 2) == 0) ins_left = NODE_CAP + 2 - gen_count;
            else ins_left = $urandom_range(0, 10);
        end
        return req;
    endfunction

    task automatic flag_result(string why, bnis_pkg::out_t got, bnis_pkg::out_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: got st %0d key %0d child %h last %0d; exp %0d %0d %h %0d",
                     $time, why, got.status, got.key_res, got.child_res, got.last,
                     want.status, want.key_res, want.child_res, want.last);
    endtask

    // request side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (cur_known) begin
                    node_apply(s_data, 1'b0);
                    push_node_result(cur_status, '0, '0, 1'b1);
                end else begin
                    node_apply(s_data, 1'b1);
                end
                req_accepted++;
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (req_offered < total_reqs &&
                         $urandom_range(0, 99) >= (idle_phase == 0 ? 20 :
                                                   idle_phase == 1 ? 70 : 0)) begin
                s_data  <= next_request();
                s_valid <= 1'b1;
                req_offered++;
                idle_phase = (req_offered * 3) / total_reqs;
                if (idle_phase > 2) idle_phase = 2;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: random stalls, one long hold-off when idling stops
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (idle_phase == 2 && !hold_done) begin
            if (hold_cycles < HOLD_CYCLES) begin
                hold_cycles++;
                m_ready <= 1'b0;
            end else begin
                hold_done = 1'b1;
                m_ready <= 1'b1;
            end
        end else begin
            m_ready <= $urandom_range(0, 99) >= (idle_phase == 0 ? 70 :
                                                 idle_phase == 1 ? 20 : 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (node_results_q.size() == 0) begin
                flag_result("unexpected result", m_data, '0);
            end else begin
                want_res = node_results_q.pop_front();
                if (m_data.status !== want_res.status || m_data.key_res !== want_res.key_res ||
                    m_data.child_res !== want_res.child_res || m_data.last !== want_res.last)
                    flag_result("result mismatch", m_data, want_res);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        // init first: no store entry is read before it is written
        add_row(bnis_pkg::CMD_INIT,   32'h0000_0000, 32'h0000_0000, 1'b1,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_SPLIT,  32'h0000_0000, 32'h0000_0000, 1'b1,
                bnis_pkg::STATUS_REJECT);
        add_row(CMD_UNKNOWN,          32'h0000_0000, 32'h0000_0000, 1'b1,
                bnis_pkg::STATUS_REJECT);
        add_row(bnis_pkg::CMD_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 1'b1,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_INSERT, 32'h8000_0000, 32'h0000_0001, 1'b1,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b1,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_INSERT, 32'h0000_0000, 32'h9abc_def0, 1'b1,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_INSERT, 32'hffff_ffff, 32'h5555_5555, 1'b1,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_INSERT, 32'h7fff_ffff, 32'haaaa_aaaa, 1'b1,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_INSERT, 32'h8000_0000, 32'h0000_0000, 1'b1,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_SPLIT,  32'h0000_0000, 32'h0000_0000, 1'b0,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_SPLIT,  32'h0000_0000, 32'h0000_0000, 1'b0,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_SPLIT,  32'h0000_0000, 32'h0000_0000, 1'b0,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_SPLIT,  32'h0000_0000, 32'h0000_0000, 1'b1,
                bnis_pkg::STATUS_REJECT);
        add_row(bnis_pkg::CMD_INIT,   32'h0000_0000, 32'hffff_ffff, 1'b1,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_INSERT, 32'h0000_0005, 32'h0000_0001, 1'b0,
                bnis_pkg::STATUS_OK);
        add_row(bnis_pkg::CMD_SPLIT,  32'h0000_0000, 32'h0000_0000, 1'b0,
                bnis_pkg::STATUS_OK);
        add_row(CMD_UNKNOWN,          32'h7fff_ffff, 32'hffff_ffff, 1'b1,
                bnis_pkg::STATUS_REJECT);
        add_row(bnis_pkg::CMD_INIT,   32'h0000_0000, 32'ha5a5_a5a5, 1'b1,
                bnis_pkg::STATUS_OK);
        total_reqs = dir_rows.size() + RANDOM_REQS;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        wait (req_accepted == total_reqs);
        while (node_results_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ btree_node_insert_split_unit.f @@
rtl/core/bnis_pkg.sv
rtl/core/bnis_mem.sv
rtl/core/btree_node_insert_split_unit.sv
dv/tb_btree_node_insert_split_unit.sv
